@@ rtl/core/slrg_pkg.sv @@
// shared constants, types and control structs of the subtractive lagged generator
package slrg_pkg;

    // field widths
    localparam int WORD_W  = 30;
    localparam int RANGE_W = 31;
    localparam int SEED_W  = 32;
    localparam int PTR_W   = 6;
    localparam int CNT_W   = 8;
    localparam int PROD_W  = WORD_W + RANGE_W;
    localparam int EST_W   = 32;

    // generator constants
    localparam int TABLE_LEN   = 55;
    localparam int SHORT_START = 24;
    localparam int FILL_STRIDE = 21;
    localparam int WARMUP      = 165;
    localparam int DIV_STEPS   = 3;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [RANGE_W-1:0] range_t;
    typedef logic [SEED_W-1:0]  seed_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    localparam word_t MOD_VAL   = WORD_W'(1000000000);
    localparam ptr_t  PTR_MAX   = PTR_W'(TABLE_LEN - 1);
    localparam ptr_t  PTR_SHORT = PTR_W'(SHORT_START);
    localparam ptr_t  PTR_FIRST = PTR_W'(FILL_STRIDE);
    localparam ptr_t  PTR_ZERO  = PTR_W'(0);
    localparam cnt_t  FILL_LAST = CNT_W'(TABLE_LEN - 1);
    localparam cnt_t  WARM_LAST = CNT_W'(WARMUP - 1);
    localparam cnt_t  DIV_LAST  = CNT_W'(DIV_STEPS - 1);

    // division by the modulus: reciprocal floor(2^61 / 1e9) and small multiples
    localparam logic [EST_W-1:0] MOD_RECIP = 32'd2305843009;
    localparam logic [EST_W-1:0] MOD_ONE   = 32'd1000000000;
    localparam logic [EST_W-1:0] MOD_TWO   = 32'd2000000000;
    localparam logic [EST_W-1:0] MOD_THREE = 32'd3000000000;

    // operation codes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // capture item and seed magnitude
        logic mod_sub;    // one conditional subtract of the modulus from the magnitude
        logic seed_wr;    // write the reduced seed to entry 0, start the fill
        logic fill_step;  // write one fill word, advance fill recurrence
        logic ptr_init;   // pointers to their start positions, clear counter
        logic rd_issue;   // step pointers and read both lag entries
        logic draw_wr;    // form the new word and write it back
        logic mul;        // register word times range, clear counter
        logic div_step;   // advance the estimate, remainder and correction stages
        logic out_load;   // load the result register
    } slrg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_reseed;
        logic n_zero;
        logic fill_done;
        logic warm_done;
        logic div_done;
    } slrg_status_t;

endpackage

@@ rtl/core/subtractive_lagged_random_generator.sv @@
// top level of the subtractive lagged random generator (lags 55 and 24, modulus 1e9)
// Items run one at a time through a controller and a datapath around a 55-word lag
// table with two registered read ports and one write port. A draw item takes one
// table read, one write-back, one multiply of the word by range_n, then division
// steps that divide the product by 1e9 (reciprocal estimate, remainder, correction)
// for bounded_value; with range_n equal to 0 the multiply and division are skipped.
// A reseed item takes conditional subtracts that reduce the seed magnitude, 55 table
// writes in stride-21 order, and 165 discarded draws, each a read, then a write-back.
// The result of an item sits in an output register, so the next item is taken while
// it waits. The seed register is written through the cfg port, which is always
// ready; it is to be written only while no item is in progress.
module subtractive_lagged_random_generator (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic signed [31:0]      cfg_seed_value,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [30:0]             s_range_n,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [29:0]             m_raw_value,
    output logic [30:0]             m_bounded_value,
    output logic                    m_range_error
);

    slrg_pkg::slrg_cmd_t    cmd;
    slrg_pkg::slrg_status_t status;

    assign cfg_ready = 1'b1;

    // sequencing
    slrg_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .m_ready     (m_ready),
        .status      (status),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .cmd         (cmd)
    );

    // arithmetic and storage
    slrg_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_seed_value  (slrg_pkg::seed_t'(cfg_seed_value)),
        .s_operation     (s_operation),
        .s_range_n       (s_range_n),
        .cmd             (cmd),
        .status          (status),
        .m_raw_value     (m_raw_value),
        .m_bounded_value (m_bounded_value),
        .m_range_error   (m_range_error)
    );

endmodule

@@ rtl/core/slrg_mem.sv @@
// lag table memory: one write port, two registered read ports, per-entry valid bits
module slrg_mem (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  we,
    input  slrg_pkg::ptr_t        waddr,
    input  slrg_pkg::word_t       wdata,
    input  logic                  re,
    input  slrg_pkg::ptr_t        raddr_a,
    input  slrg_pkg::ptr_t        raddr_b,
    output slrg_pkg::word_t       rdata_a,
    output slrg_pkg::word_t       rdata_b
);

    slrg_pkg::word_t mem [slrg_pkg::TABLE_LEN];
    logic            vld_reg [slrg_pkg::TABLE_LEN];
    slrg_pkg::word_t rd_a_reg;
    slrg_pkg::word_t rd_b_reg;
    logic            rd_a_vld_reg;
    logic            rd_b_vld_reg;

    // storage array and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    // valid bits, an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < slrg_pkg::TABLE_LEN; i++) begin
                vld_reg[i] <= 1'b0;
            end
            rd_a_vld_reg <= 1'b0;
            rd_b_vld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_a_vld_reg <= vld_reg[raddr_a];
                rd_b_vld_reg <= vld_reg[raddr_b];
            end
        end
    end

    assign rdata_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign rdata_b = rd_b_vld_reg ? rd_b_reg : '0;

endmodule

@@ rtl/core/slrg_dpath.sv @@
// datapath: seed register, pointers, fill recurrence, lag table, multiplier and divider
module slrg_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  slrg_pkg::seed_t         cfg_seed_value,
    input  logic                    s_operation,
    input  slrg_pkg::range_t        s_range_n,
    input  slrg_pkg::slrg_cmd_t     cmd,
    output slrg_pkg::slrg_status_t  status,
    output slrg_pkg::word_t         m_raw_value,
    output slrg_pkg::range_t        m_bounded_value,
    output logic                    m_range_error
);

    // pointer step with wrap to the top entry
    function automatic slrg_pkg::ptr_t step_ptr(input slrg_pkg::ptr_t p);
        if (p == slrg_pkg::PTR_ZERO || p > slrg_pkg::PTR_MAX) begin
            return slrg_pkg::PTR_MAX;
        end
        return p - 1'b1;
    endfunction

    // a - b modulo the modulus, both below it
    function automatic slrg_pkg::word_t sub_mod(input slrg_pkg::word_t a,
                                                input slrg_pkg::word_t b);
        if (a >= b) begin
            return a - b;
        end
        return a + (slrg_pkg::MOD_VAL - b);
    endfunction

    slrg_pkg::seed_t  seed_reg;
    logic             op_reg;
    slrg_pkg::range_t n_reg;
    slrg_pkg::seed_t  mag_reg;
    slrg_pkg::seed_t  mag_next;
    slrg_pkg::ptr_t   long_ptr_reg;
    slrg_pkg::ptr_t   short_ptr_reg;
    slrg_pkg::ptr_t   fill_pos_reg;
    slrg_pkg::ptr_t   fill_pos_next;
    logic [slrg_pkg::PTR_W:0] fill_pos_sum;
    slrg_pkg::word_t  fill_last_reg;
    slrg_pkg::word_t  fill_next_reg;
    slrg_pkg::cnt_t   cnt_reg;
    slrg_pkg::cnt_t   cnt_next;
    slrg_pkg::word_t  w_reg;
    slrg_pkg::word_t  w_new;
    logic [slrg_pkg::PROD_W-1:0]    prod;
    logic [slrg_pkg::PROD_W-1:0]    prod_reg;
    logic [2*slrg_pkg::EST_W-1:0]   est_prod;
    slrg_pkg::range_t               qest_reg;
    logic [slrg_pkg::EST_W-1:0]     rem_reg;
    logic [slrg_pkg::EST_W-1:0]     rem_next;
    slrg_pkg::range_t low_reg;
    slrg_pkg::word_t  out_raw_reg;
    slrg_pkg::range_t out_bnd_reg;
    logic             out_err_reg;
    logic             mem_we;
    slrg_pkg::ptr_t   mem_waddr;
    slrg_pkg::word_t  mem_wdata;
    slrg_pkg::word_t  rd_long;
    slrg_pkg::word_t  rd_short;

    // seed configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_we) begin
            seed_reg <= cfg_seed_value;
        end
    end

    // seed magnitude: absolute value, then reduced by conditional subtracts
    always_comb begin
        mag_next = mag_reg;
        if (cmd.accept) begin
            mag_next = seed_reg[slrg_pkg::SEED_W-1] ? (~seed_reg + 1'b1) : seed_reg;
        end else if (cmd.mod_sub && mag_reg >= slrg_pkg::SEED_W'(slrg_pkg::MOD_VAL)) begin
            mag_next = mag_reg - slrg_pkg::SEED_W'(slrg_pkg::MOD_VAL);
        end
    end

    // item capture and magnitude
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_operation;
            n_reg  <= s_range_n;
        end
        mag_reg <= mag_next;
    end

    // lag pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_ptr_reg  <= '0;
            short_ptr_reg <= '0;
        end else if (cmd.ptr_init) begin
            long_ptr_reg  <= slrg_pkg::PTR_ZERO;
            short_ptr_reg <= slrg_pkg::PTR_SHORT;
        end else if (cmd.rd_issue) begin
            long_ptr_reg  <= step_ptr(long_ptr_reg);
            short_ptr_reg <= step_ptr(short_ptr_reg);
        end
    end

    // fill order position: add the stride, wrap past the table end
    always_comb begin
        fill_pos_sum = {1'b0, fill_pos_reg} + (slrg_pkg::PTR_W + 1)'(slrg_pkg::FILL_STRIDE);
        if (fill_pos_sum > (slrg_pkg::PTR_W + 1)'(slrg_pkg::PTR_MAX)) begin
            fill_pos_next = slrg_pkg::PTR_W'(fill_pos_sum
                            - (slrg_pkg::PTR_W + 1)'(slrg_pkg::TABLE_LEN));
        end else begin
            fill_pos_next = fill_pos_sum[slrg_pkg::PTR_W-1:0];
        end
    end

    // fill recurrence registers
    always_ff @(posedge aclk) begin
        if (cmd.seed_wr) begin
            fill_pos_reg  <= slrg_pkg::PTR_FIRST;
            fill_last_reg <= mag_reg[slrg_pkg::WORD_W-1:0];
            fill_next_reg <= slrg_pkg::WORD_W'(1);
        end else if (cmd.fill_step) begin
            fill_pos_reg  <= fill_pos_next;
            fill_last_reg <= fill_next_reg;
            fill_next_reg <= sub_mod(fill_last_reg, fill_next_reg);
        end
    end

    // shared step counter
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ptr_init || cmd.mul) begin
            cnt_next = '0;
        end else if (cmd.seed_wr) begin
            cnt_next = slrg_pkg::CNT_W'(1);
        end else if (cmd.fill_step || cmd.draw_wr || cmd.div_step) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // table write port selection
    assign w_new = sub_mod(rd_long, rd_short);

    always_comb begin
        mem_we    = cmd.seed_wr | cmd.fill_step | cmd.draw_wr;
        mem_waddr = long_ptr_reg;
        mem_wdata = w_new;
        if (cmd.seed_wr) begin
            mem_waddr = slrg_pkg::PTR_ZERO;
            mem_wdata = mag_reg[slrg_pkg::WORD_W-1:0];
        end else if (cmd.fill_step) begin
            mem_waddr = fill_pos_reg;
            mem_wdata = fill_next_reg;
        end
    end

    slrg_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (cmd.rd_issue),
        .raddr_a (step_ptr(long_ptr_reg)),
        .raddr_b (step_ptr(short_ptr_reg)),
        .rdata_a (rd_long),
        .rdata_b (rd_short)
    );

    // drawn word
    always_ff @(posedge aclk) begin
        if (cmd.draw_wr) begin
            w_reg <= w_new;
        end
    end

    // product, then division by the modulus in three stages:
    // reciprocal estimate from the top 32 product bits (at most two short),
    // remainder in the low 32 bits, and a final correction of up to two
    assign prod     = slrg_pkg::PROD_W'(w_reg) * slrg_pkg::PROD_W'(n_reg);
    assign est_prod = (2*slrg_pkg::EST_W)'(
                          prod_reg[slrg_pkg::PROD_W-1:slrg_pkg::PROD_W-slrg_pkg::EST_W])
                      * (2*slrg_pkg::EST_W)'(slrg_pkg::MOD_RECIP);
    assign rem_next = prod_reg[slrg_pkg::EST_W-1:0]
                      - slrg_pkg::EST_W'(qest_reg) * slrg_pkg::MOD_ONE;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= prod;
        end
        if (cmd.div_step) begin
            qest_reg <= est_prod[slrg_pkg::EST_W+slrg_pkg::RANGE_W-1:slrg_pkg::EST_W];
            rem_reg  <= rem_next;
            if (rem_reg >= slrg_pkg::MOD_TWO) begin
                low_reg <= qest_reg + slrg_pkg::RANGE_W'(2);
            end else if (rem_reg >= slrg_pkg::MOD_ONE) begin
                low_reg <= qest_reg + slrg_pkg::RANGE_W'(1);
            end else begin
                low_reg <= qest_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_raw_reg <= status.is_reseed ? '0 : w_reg;
            out_bnd_reg <= (status.is_reseed || status.n_zero) ? '0 : low_reg;
            out_err_reg <= !status.is_reseed && status.n_zero;
        end
    end

    assign m_raw_value     = out_raw_reg;
    assign m_bounded_value = out_bnd_reg;
    assign m_range_error   = out_err_reg;

    // status to the controller
    assign status.is_reseed = (op_reg == slrg_pkg::OP_RESEED);
    assign status.n_zero    = (n_reg == '0);
    assign status.fill_done = (cnt_reg == slrg_pkg::FILL_LAST);
    assign status.warm_done = (cnt_reg == slrg_pkg::WARM_LAST);
    assign status.div_done  = (cnt_reg == slrg_pkg::DIV_LAST);

    // pointers stay inside the table
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        long_ptr_reg <= slrg_pkg::PTR_MAX && short_ptr_reg <= slrg_pkg::PTR_MAX)
        else $error("lag pointer outside the table");

    // the estimate is never more than two short of the quotient
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && !status.is_reseed && !status.n_zero)
        |-> rem_reg < slrg_pkg::MOD_THREE)
        else $error("division remainder not reduced");

    // a bounded result stays below its range
    a_bound_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && !status.is_reseed && !status.n_zero) |-> low_reg < n_reg)
        else $error("bounded result not below its range");

endmodule

@@ rtl/core/slrg_ctrl.sv @@
// controller: sequences reseed, warm-up, draw, division and result hand-off
module slrg_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_operation,
    input  logic                    m_ready,
    input  slrg_pkg::slrg_status_t  status,
    output logic                    s_ready,
    output logic                    m_valid,
    output slrg_pkg::slrg_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD1  = 4'd1;
    localparam logic [3:0] S_MOD2  = 4'd2;
    localparam logic [3:0] S_FILL0 = 4'd3;
    localparam logic [3:0] S_FILL  = 4'd4;
    localparam logic [3:0] S_WRD   = 4'd5;
    localparam logic [3:0] S_WCALC = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DCALC = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_operation == slrg_pkg::OP_RESEED) ? S_MOD1 : S_DRD;
                end
            end
            S_MOD1: begin
                cmd.mod_sub = 1'b1;
                state_next  = S_MOD2;
            end
            S_MOD2: begin
                cmd.mod_sub = 1'b1;
                state_next  = S_FILL0;
            end
            S_FILL0: begin
                cmd.seed_wr = 1'b1;
                state_next  = S_FILL;
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_done) begin
                    cmd.ptr_init = 1'b1;
                    state_next   = S_WRD;
                end
            end
            S_WRD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_WCALC;
            end
            S_WCALC: begin
                cmd.draw_wr = 1'b1;
                state_next  = status.warm_done ? S_OUT : S_WRD;
            end
            S_DRD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DCALC;
            end
            S_DCALC: begin
                cmd.draw_wr = 1'b1;
                state_next  = status.n_zero ? S_OUT : S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("result register loaded while an item waits");

    // one item at a time: no second accept straight after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    // a new result appears only from the hand-off state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result valid raised outside the hand-off state");

endmodule

@@ test/subtractive_lagged_random_generator_test.sv @@
// testbench for the subtractive lagged random generator: predictor, scoreboard and drivers
module subtractive_lagged_random_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1150;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        slrg_pkg::word_t  raw;
        slrg_pkg::range_t bounded;
        logic             range_err;
    } draw_result_t;

    // predicts the generator and checks its results in order
    class draw_scoreboard;
        slrg_pkg::word_t  lag_words [slrg_pkg::TABLE_LEN];
        slrg_pkg::ptr_t   long_pos;
        slrg_pkg::ptr_t   short_pos;
        slrg_pkg::seed_t  seed_reg;
        draw_result_t     expected_draws [$];
        int               failures;

        function new();
            foreach (lag_words[i]) lag_words[i] = '0;
            long_pos  = slrg_pkg::PTR_ZERO;
            short_pos = slrg_pkg::PTR_ZERO;
            seed_reg  = '0;
            failures  = 0;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function void set_seed(slrg_pkg::seed_t value);
            seed_reg = value;
        endfunction

        // a - b modulo 1e9, both operands already reduced
        function slrg_pkg::word_t mod_diff(slrg_pkg::word_t a, slrg_pkg::word_t b);
            logic [31:0] t;
            t = 32'(a) + 32'(slrg_pkg::MOD_VAL) - 32'(b);
            if (t >= 32'(slrg_pkg::MOD_VAL)) t = t - 32'(slrg_pkg::MOD_VAL);
            return t[slrg_pkg::WORD_W-1:0];
        endfunction

        function slrg_pkg::ptr_t step_back(slrg_pkg::ptr_t p);
            if (p == slrg_pkg::PTR_ZERO || p >= slrg_pkg::ptr_t'(slrg_pkg::TABLE_LEN))
                return slrg_pkg::PTR_MAX;
            return p - 1'b1;
        endfunction

        // one lagged subtraction, written back at the long lag
        function slrg_pkg::word_t next_word();
            slrg_pkg::word_t w;
            long_pos  = step_back(long_pos);
            short_pos = step_back(short_pos);
            w = mod_diff(lag_words[long_pos], lag_words[short_pos]);
            lag_words[long_pos] = w;
            return w;
        endfunction

        // table fill in stride-21 order followed by the discarded warm-up draws
        function void refill();
            logic [31:0]     mag;
            slrg_pkg::word_t last;
            slrg_pkg::word_t fill;
            int              pos;
            mag = seed_reg[slrg_pkg::SEED_W-1] ? (32'd0 - seed_reg) : seed_reg;
            mag = mag % 32'(slrg_pkg::MOD_VAL);
            lag_words[0] = mag[slrg_pkg::WORD_W-1:0];
            last = mag[slrg_pkg::WORD_W-1:0];
            fill = slrg_pkg::word_t'(1);
            for (int i = 1; i < slrg_pkg::TABLE_LEN; i++) begin
                pos = (slrg_pkg::FILL_STRIDE * i) % slrg_pkg::TABLE_LEN;
                lag_words[pos] = fill;
                fill = mod_diff(last, fill);
                last = lag_words[pos];
            end
            long_pos  = slrg_pkg::PTR_ZERO;
            short_pos = slrg_pkg::PTR_SHORT;
            repeat (slrg_pkg::WARMUP) void'(next_word());
        endfunction

        function void note_item(logic op, slrg_pkg::range_t n);
            draw_result_t r;
            logic [63:0]  prod;
            r.raw = '0;
            r.bounded = '0;
            r.range_err = 1'b0;
            if (op == slrg_pkg::OP_RESEED) begin
                refill();
            end else begin
                r.raw = next_word();
                if (n == '0) begin
                    r.range_err = 1'b1;
                end else begin
                    prod = 64'(r.raw) * 64'(n);
                    r.bounded = slrg_pkg::range_t'(prod / 64'(slrg_pkg::MOD_VAL));
                end
            end
            expected_draws.push_back(r);
        endfunction

        function void check_result(slrg_pkg::word_t raw, slrg_pkg::range_t bounded,
                                   logic range_err);
            draw_result_t r;
            if (expected_draws.size() == 0) begin
                failures++;
                $display("%0t: result with none expected, raw_value %0d", $time, raw);
                return;
            end
            r = expected_draws.pop_front();
            if (raw !== r.raw) begin
                failures++;
                $display("%0t: raw_value expected %0d got %0d", $time, r.raw, raw);
            end
            if (bounded !== r.bounded) begin
                failures++;
                $display("%0t: bounded_value expected %0d got %0d", $time, r.bounded, bounded);
            end
            if (range_err !== r.range_err) begin
                failures++;
                $display("%0t: range_error expected %0b got %0b", $time, r.range_err,
                         range_err);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [31:0]      cfg_seed_value;
    logic             s_valid;
    logic             s_ready;
    logic             s_operation;
    slrg_pkg::range_t s_range_n;
    logic             m_valid;
    logic             m_ready;
    slrg_pkg::word_t  m_raw_value;
    slrg_pkg::range_t m_bounded_value;
    logic             m_range_error;

    draw_scoreboard sb = new();
    int             items_sent = 0;
    int             hold_requests = 0;

    subtractive_lagged_random_generator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_seed_value  (cfg_seed_value),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_range_n       (s_range_n),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_raw_value     (m_raw_value),
        .m_bounded_value (m_bounded_value),
        .m_range_error   (m_range_error)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // observe every handshake at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_seed(cfg_seed_value);
            if (s_valid && s_ready) sb.note_item(s_operation, s_range_n);
            if (m_valid && m_ready) sb.check_result(m_raw_value, m_bounded_value,
                                                    m_range_error);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic slrg_pkg::range_t pick_range();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return slrg_pkg::range_t'(1);
            3:       return slrg_pkg::range_t'($urandom_range(2, 1000));
            4, 5:    return slrg_pkg::range_t'($urandom_range(1, 1000000000));
            default: return slrg_pkg::range_t'($urandom);
        endcase
    endfunction

    // result side: random back-pressure plus a long hold-off on each request
    initial begin
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_requests > holds_done) begin
                holds_done++;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                case ($urandom_range(0, 19))
                    0:       begin m_ready = 1'b0; repeat ($urandom_range(15, 60)) @(negedge aclk); end
                    1, 2, 3: begin m_ready = 1'b0; repeat ($urandom_range(1, 3)) @(negedge aclk); end
                    default: begin m_ready = 1'b1; repeat ($urandom_range(1, 40)) @(negedge aclk); end
                endcase
            end
        end
    end

    // offer one item, after a random gap, and wait for it to be taken
    task automatic send_item(logic op, slrg_pkg::range_t n);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation = op;
        s_range_n   = n;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // seed writes only once the block has gone idle
    task automatic write_seed(slrg_pkg::seed_t value);
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        cfg_seed_value = value;
        cfg_valid      = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial begin
        slrg_pkg::seed_t seed_corners [8];
        int              phase;
        int              draws;
        slrg_pkg::seed_t s;

        seed_corners = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'h0000_0001, 32'd999999999, 32'd1000000000, 32'hC465_3600};
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_seed_value = '0;
        s_valid        = 1'b0;
        s_operation    = slrg_pkg::OP_DRAW;
        s_range_n      = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // draws from the all-zero table before any reseed
        send_item(slrg_pkg::OP_DRAW, '0);
        send_item(slrg_pkg::OP_DRAW, '1);
        // reseed from the reset seed, then the range extremes
        send_item(slrg_pkg::OP_RESEED, '1);
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(1));
        send_item(slrg_pkg::OP_DRAW, '1);
        send_item(slrg_pkg::OP_DRAW, '0);
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(1000000000));
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(999999999));
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(2));
        // most negative seed
        write_seed(32'h8000_0000);
        send_item(slrg_pkg::OP_RESEED, '0);
        send_item(slrg_pkg::OP_DRAW, '1);
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(1));
        send_item(slrg_pkg::OP_DRAW, '0);
        // most positive seed
        write_seed(32'h7FFF_FFFF);
        send_item(slrg_pkg::OP_RESEED, '0);
        send_item(slrg_pkg::OP_DRAW, '1);
        send_item(slrg_pkg::OP_DRAW, slrg_pkg::range_t'(1000000000));
        // minus one, and a back-to-back reseed
        write_seed(32'hFFFF_FFFF);
        send_item(slrg_pkg::OP_RESEED, slrg_pkg::range_t'(12345));
        send_item(slrg_pkg::OP_RESEED, '1);
        send_item(slrg_pkg::OP_DRAW, '1);

        // random phases: a seed, usually a reseed, then a run of draws with occasional reseeds
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            s = (phase < 8) ? seed_corners[phase] : slrg_pkg::seed_t'($urandom);
            write_seed(s);
            if (phase < 8 || $urandom_range(0, 4) != 0)
                send_item(slrg_pkg::OP_RESEED, pick_range());
            if (phase == 3 || phase == 11) hold_requests++;
            draws = $urandom_range(20, 80);
            repeat (draws) begin
                if ($urandom_range(0, 39) == 0) send_item(slrg_pkg::OP_RESEED, pick_range());
                else send_item(slrg_pkg::OP_DRAW, pick_range());
            end
            phase++;
        end

        // drain and let the longest item time out
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/slrg_pkg.sv
rtl/core/slrg_mem.sv
rtl/core/slrg_dpath.sv
rtl/core/slrg_ctrl.sv
rtl/core/subtractive_lagged_random_generator.sv
test/subtractive_lagged_random_generator_test.sv
